[rtl/core/fbb_pkg.sv]
// Shared types and constants for the formant biquad bank.
`timescale 1ns / 1ps
package fbb_pkg;

  localparam int SCALE_BITS    = 16;
  localparam int SCALE_FRAC    = 15;
  localparam int COUNT_BITS    = 3;
  localparam int FILTER_GUARD  = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int NUM_COEF_REGS = 5;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_COEF_A   = 3'd0;
  localparam cfg_idx_t REG_FORMANTS = 3'd5;
  localparam cfg_idx_t REG_SCALE    = 3'd6;

  localparam logic [COUNT_BITS-1:0] FORMANTS_RESET = 3'd5;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET    = 16'd14654;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT_GO,
    ST_FILT_WAIT,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_OUT
  } fbb_state_t;

endpackage

[rtl/core/fbb_mac.sv]
// Bit-serial biquad multiply-accumulate with rounding and saturation.
`timescale 1ns / 1ps
module fbb_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                start,
  input  logic signed [COEF_BITS-1:0]                         b0,
  input  logic signed [COEF_BITS-1:0]                         a1,
  input  logic signed [COEF_BITS-1:0]                         a2,
  input  logic signed [SAMPLE_BITS:0]                         diff,
  input  logic signed [SAMPLE_BITS+fbb_pkg::FILTER_GUARD-1:0] y1,
  input  logic signed [SAMPLE_BITS+fbb_pkg::FILTER_GUARD-1:0] y2,
  output logic                                                done,
  output logic signed [SAMPLE_BITS+fbb_pkg::FILTER_GUARD-1:0] y
);
  import fbb_pkg::*;

  localparam int FILTER_BITS = SAMPLE_BITS + FILTER_GUARD;
  localparam int COEF_FRAC   = COEF_BITS - 2;
  localparam int TERM_W      = FILTER_BITS + 3;
  localparam int ACC_W       = FILTER_BITS + COEF_BITS + 2;
  localparam int SH_W        = ACC_W + 1 - COEF_FRAC;
  localparam int CNT_W       = $clog2(COEF_BITS + 1);
  localparam logic signed [SH_W-1:0] Y_MAX = SH_W'((64'sd1 <<< (FILTER_BITS - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] Y_MIN = SH_W'(-(64'sd1 <<< (FILTER_BITS - 1)));

  logic [COEF_BITS-1:0]          b0_sh, a1_sh, a2_sh;
  logic signed [SAMPLE_BITS:0]   d_reg;
  logic signed [FILTER_BITS-1:0] y1_reg, y2_reg;
  logic signed [ACC_W-1:0]       acc, acc_next;
  logic [CNT_W-1:0]              cnt;
  logic                          busy, rnd, first;
  logic signed [TERM_W-1:0]      term_b, term_1, term_2, term;
  logic signed [ACC_W:0]         rsum;
  logic signed [SH_W-1:0]        shifted;
  logic signed [FILTER_BITS-1:0] y_sat;

  // Horner over coefficient bits, MSB first; the MSB carries negative weight
  always_comb begin
    first   = (cnt == CNT_W'(COEF_BITS));
    term_b  = b0_sh[COEF_BITS-1] ? TERM_W'(d_reg) : '0;
    term_1  = a1_sh[COEF_BITS-1] ? TERM_W'(y1_reg) : '0;
    term_2  = a2_sh[COEF_BITS-1] ? TERM_W'(y2_reg) : '0;
    term    = first ? (term_1 + term_2 - term_b) : (term_b - term_1 - term_2);
    acc_next = (acc <<< 1) + ACC_W'(term);
    rsum    = (ACC_W+1)'(acc) + (ACC_W+1)'(1 <<< (COEF_FRAC - 1));
    shifted = SH_W'(rsum >>> COEF_FRAC);
    if (shifted > Y_MAX) begin
      y_sat = FILTER_BITS'(Y_MAX);
    end else if (shifted < Y_MIN) begin
      y_sat = FILTER_BITS'(Y_MIN);
    end else begin
      y_sat = FILTER_BITS'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(COEF_BITS);
        acc    <= '0;
        b0_sh  <= b0;
        a1_sh  <= a1;
        a2_sh  <= a2;
        d_reg  <= diff;
        y1_reg <= y1;
        y2_reg <= y2;
      end else if (busy) begin
        acc   <= acc_next;
        b0_sh <= b0_sh << 1;
        a1_sh <= a1_sh << 1;
        a2_sh <= a2_sh << 1;
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          rnd  <= 1'b1;
        end
      end else if (rnd) begin
        rnd  <= 1'b0;
        done <= 1'b1;
        y    <= y_sat;
      end
    end
  end

endmodule

[rtl/core/fbb_scale.sv]
// Bit-serial output scaler: sum times unsigned Q1.15 gain, round, saturate.
`timescale 1ns / 1ps
module fbb_scale #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 27
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [SUM_BITS-1:0]          sum,
  input  logic [fbb_pkg::SCALE_BITS-1:0]      scale,
  output logic                                done,
  output logic signed [SAMPLE_BITS-1:0]       result
);
  import fbb_pkg::*;

  localparam int P_W   = SUM_BITS + SCALE_BITS + 1;
  localparam int SH_W  = P_W + 1 - SCALE_FRAC;
  localparam int CNT_W = $clog2(SCALE_BITS + 1);
  localparam logic signed [SH_W-1:0] S_MAX = SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] S_MIN = SH_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic [SCALE_BITS-1:0]        sc_sh;
  logic signed [SUM_BITS-1:0]   sum_reg;
  logic signed [P_W-1:0]        prod, prod_next;
  logic [CNT_W-1:0]             cnt;
  logic                         busy, rnd;
  logic signed [P_W:0]          rprod;
  logic signed [SH_W-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  always_comb begin
    prod_next = (prod <<< 1) + (sc_sh[SCALE_BITS-1] ? P_W'(sum_reg) : '0);
    rprod     = (P_W+1)'(prod) + (P_W+1)'(1 <<< (SCALE_FRAC - 1));
    shifted   = SH_W'(rprod >>> SCALE_FRAC);
    if (shifted > S_MAX) begin
      res_sat = SAMPLE_BITS'(S_MAX);
    end else if (shifted < S_MIN) begin
      res_sat = SAMPLE_BITS'(S_MIN);
    end else begin
      res_sat = SAMPLE_BITS'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(SCALE_BITS);
        prod    <= '0;
        sc_sh   <= scale;
        sum_reg <= sum;
      end else if (busy) begin
        prod  <= prod_next;
        sc_sh <= sc_sh << 1;
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          rnd  <= 1'b1;
        end
      end else if (rnd) begin
        rnd    <= 1'b0;
        done   <= 1'b1;
        result <= res_sat;
      end
    end
  end

endmodule

[rtl/core/formant_biquad_bank_top.sv]
// Top level of the formant biquad bank: config registers, filter state, sequencer.
// Each request runs the bit-serial MAC once per formant in use, then the bit-serial scaler,
//   before the result goes to the output register.
// Only one request is in flight at a time; the bit-serial MAC and scaler set the pace.
// The next input is taken as soon as a result sits in the output register.
// Reset (synchronous, active high): coefficients and filter state cleared, count 5, scale 14654.
`timescale 1ns / 1ps
module formant_biquad_bank_top #(
  parameter int MAX_FORMANTS = 5,
  parameter int SAMPLE_BITS  = 16,
  parameter int COEF_BITS    = 18
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [fbb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [3*COEF_BITS-1:0]             cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic                               block_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample,
  output logic                               out_block_end
);
  import fbb_pkg::*;

  localparam int FILTER_BITS = SAMPLE_BITS + FILTER_GUARD;
  localparam int SUM_BITS    = FILTER_BITS + $clog2(MAX_FORMANTS + 1);
  localparam int K_CNT_W     = $clog2(MAX_FORMANTS + 1);
  localparam int K_IDX_W     = (MAX_FORMANTS > 1) ? $clog2(MAX_FORMANTS) : 1;

  // Configuration registers. Formants without a register keep zero coefficients.
  logic [3*COEF_BITS-1:0]        coef [MAX_FORMANTS];
  logic [COUNT_BITS-1:0]         formants_in_use;
  logic [SCALE_BITS-1:0]         output_scale;

  // Shared input delay line and per-filter output history
  logic signed [SAMPLE_BITS-1:0] delay_one, delay_two;
  logic signed [FILTER_BITS-1:0] y1_mem [MAX_FORMANTS];
  logic signed [FILTER_BITS-1:0] y2_mem [MAX_FORMANTS];

  // Per-request working registers
  logic signed [SAMPLE_BITS:0]   diff;
  logic                          blk;
  logic signed [SUM_BITS-1:0]    sum;
  logic [K_CNT_W-1:0]            k, k_lim, k_lim_c;
  logic [K_IDX_W-1:0]            k_idx;

  fbb_state_t                    state, state_next;
  logic                          mac_start, mac_done, scale_start, scale_done, out_load;
  logic                          in_acc;
  logic signed [FILTER_BITS-1:0] mac_y;
  logic signed [SAMPLE_BITS-1:0] scale_y;
  logic [3*COEF_BITS-1:0]        cur_coef;

  assign in_acc   = in_valid && in_ready;
  assign k_idx    = k[K_IDX_W-1:0];
  assign cur_coef = coef[k_idx];

  // Count is clipped to the number of filters built
  assign k_lim_c = (32'(formants_in_use) > MAX_FORMANTS) ? K_CNT_W'(MAX_FORMANTS)
                                                         : K_CNT_W'(formants_in_use);

  // --- configuration port ---
  for (genvar j = 0; j < MAX_FORMANTS; j++) begin : g_coef
    always_ff @(posedge clk) begin
      if (rst) begin
        coef[j] <= '0;
      end else if (cfg_write && (j < NUM_COEF_REGS) &&
                   (cfg_index == REG_COEF_A + CFG_IDX_BITS'(j))) begin
        coef[j] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      formants_in_use <= FORMANTS_RESET;
      output_scale    <= SCALE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FORMANTS) begin
        formants_in_use <= cfg_data[COUNT_BITS-1:0];
      end
      if (cfg_index == REG_SCALE) begin
        output_scale <= cfg_data[SCALE_BITS-1:0];
      end
    end
  end

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    mac_start   = 1'b0;
    scale_start = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // a count of zero skips straight to the scaler with a zero sum
          state_next = (k_lim_c == '0) ? ST_SCALE_GO : ST_FILT_GO;
        end
      end
      ST_FILT_GO: begin
        mac_start  = 1'b1;
        state_next = ST_FILT_WAIT;
      end
      ST_FILT_WAIT: begin
        if (mac_done) begin
          state_next = (k + 1'b1 == k_lim) ? ST_SCALE_GO : ST_FILT_GO;
        end
      end
      ST_SCALE_GO: begin
        scale_start = 1'b1;
        state_next  = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (scale_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // scaler holds its result until the output register has room
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --- input capture, delay line and filter history ---
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
      k         <= '0;
      k_lim     <= '0;
      for (int i = 0; i < MAX_FORMANTS; i++) begin
        y1_mem[i] <= '0;
        y2_mem[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        // b0*x - b0*x2 folds into b0*(x - x2)
        diff      <= (SAMPLE_BITS+1)'(in_sample) - (SAMPLE_BITS+1)'(delay_two);
        blk       <= block_end;
        delay_two <= delay_one;
        delay_one <= in_sample;
        sum       <= '0;
        k         <= '0;
        k_lim     <= k_lim_c;
      end else if (state == ST_FILT_WAIT && mac_done) begin
        y2_mem[k_idx] <= y1_mem[k_idx];
        y1_mem[k_idx] <= mac_y;
        sum           <= sum + SUM_BITS'(mac_y);
        k             <= k + 1'b1;
      end
    end
  end

  fbb_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .b0    ($signed(cur_coef[COEF_BITS-1:0])),
    .a1    ($signed(cur_coef[2*COEF_BITS-1:COEF_BITS])),
    .a2    ($signed(cur_coef[3*COEF_BITS-1:2*COEF_BITS])),
    .diff  (diff),
    .y1    (y1_mem[k_idx]),
    .y2    (y2_mem[k_idx]),
    .done  (mac_done),
    .y     (mac_y)
  );

  fbb_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .sum    (sum),
    .scale  (output_scale),
    .done   (scale_done),
    .result (scale_y)
  );

  // --- output register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample    <= scale_y;
      out_block_end <= blk;
    end
  end

endmodule

[rtl/core/fbb_checker.sv]
// Port-level assertions for the formant biquad bank, bound to the top level.
`timescale 1ns / 1ps
module fbb_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic                          out_block_end
);

  // stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_block_end))
    else $error("output request changed while stalled");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // no result can appear the cycle after its input was taken
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
    else $error("output appeared too early");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind formant_biquad_bank_top fbb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fbb_checker (.*);

[test/formant_bank_checker.sv]
// Checker for the formant bank: follows config writes, predicts every output and compares.
`timescale 1ns / 1ps
module formant_bank_checker
  import fbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  cfg_idx_t           cfg_index,
  input  logic [53:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               block_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_sample,
  input  logic               out_block_end,
  output int                 mismatch_count,
  output int                 outstanding
);

  localparam int BANK_SIZE = 5;
  localparam int SMP_BITS  = 16;
  localparam int FILT_BITS = SMP_BITS + FILTER_GUARD;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 2;

  typedef struct packed {
    logic signed [SMP_BITS-1:0] sample;
    logic                       block_end;
  } bank_out_t;

  // shadow of the register file and of the filter history
  logic [3*COEF_W-1:0]   coef_bank [BANK_SIZE];
  logic [COUNT_BITS-1:0] formant_count;
  logic [SCALE_BITS-1:0] gain_q15;
  longint                x_d1, x_d2;
  longint                y_d1 [BANK_SIZE];
  longint                y_d2 [BANK_SIZE];
  bank_out_t             expected_out [$];
  int                    errs = 0;

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one sample through the bank; updates the history
  function bank_out_t formant_bank_step(logic signed [SMP_BITS-1:0] s, logic be);
    longint    x, b0, a1, a2, acc, y, sum, scaled;
    int        n;
    bank_out_t r;
    x   = s;
    sum = 0;
    n   = (formant_count > BANK_SIZE) ? BANK_SIZE : int'(formant_count);
    for (int k = 0; k < n; k++) begin
      b0  = $signed(coef_bank[k][COEF_W-1:0]);
      a1  = $signed(coef_bank[k][2*COEF_W-1:COEF_W]);
      a2  = $signed(coef_bank[k][3*COEF_W-1:2*COEF_W]);
      acc = b0 * x - b0 * x_d2 - a1 * y_d1[k] - a2 * y_d2[k];
      y   = clamp((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, FILT_BITS);
      y_d2[k] = y_d1[k];
      y_d1[k] = y;
      sum = sum + y;
    end
    x_d2 = x_d1;
    x_d1 = x;
    scaled = (sum * longint'(gain_q15) + (longint'(1) <<< (SCALE_FRAC - 1))) >>> SCALE_FRAC;
    scaled = clamp(scaled, SMP_BITS);
    r.sample    = scaled[SMP_BITS-1:0];
    r.block_end = be;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bank_out_t exp_r;
    if (rst) begin
      for (int k = 0; k < BANK_SIZE; k++) begin
        coef_bank[k] = '0;
        y_d1[k]      = 0;
        y_d2[k]      = 0;
      end
      formant_count = FORMANTS_RESET;
      gain_q15      = SCALE_RESET;
      x_d1          = 0;
      x_d2          = 0;
      expected_out.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected output request, out_sample %0d out_block_end %0b",
                     $time, out_sample, out_block_end);
        end else begin
          exp_r = expected_out.pop_front();
          if (out_sample !== exp_r.sample || out_block_end !== exp_r.block_end) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch, out_sample exp %0d got %0d, out_block_end exp %0b got %0b",
                       $time, exp_r.sample, out_sample, exp_r.block_end, out_block_end);
          end
        end
      end
      if (in_valid && in_ready)
        expected_out.push_back(formant_bank_step(in_sample, block_end));
      if (cfg_write) begin
        if (cfg_index < NUM_COEF_REGS)
          coef_bank[cfg_index] = cfg_data;
        else if (cfg_index == REG_FORMANTS)
          formant_count = cfg_data[COUNT_BITS-1:0];
        else if (cfg_index == REG_SCALE)
          gain_q15 = cfg_data[SCALE_BITS-1:0];
        // other indexes write nothing
      end
    end
    outstanding    <= expected_out.size();
    mismatch_count <= errs;
  end

endmodule

[test/tb_top.sv]
// Testbench top for the formant biquad bank: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
  import fbb_pkg::*;

  // index past the last register; writes to it must leave the bank untouched
  localparam cfg_idx_t REG_UNUSED = 3'd7;
  // long receiver hold-off, well beyond one sample's latency at five formants
  localparam int LONG_HOLD = 400;
  localparam int PHASES    = 12;
  localparam int PER_PHASE = 152;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  cfg_idx_t           cfg_index;
  logic [53:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_sample;
  logic               block_end;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_sample;
  logic               out_block_end;

  int   mismatch_count;
  int   outstanding;
  // steady: no gaps on either side for the current phase
  logic steady = 1'b0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int   hold_ticket = 0;

  // 1/sqrt(n) in Q1.15, as software would set the scale
  int unsigned norm_gain [1:5] = '{32768, 23170, 18919, 16384, 14654};

  formant_biquad_bank_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_block_end(out_block_end)
  );

  formant_bank_checker bank_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_block_end (out_block_end),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bandpass-like biquad inside the stability triangle: a2 in [0.25, 0.99],
  // |a1| < 1 + a2, small b0. Packed as {a2, a1, b0}, Q2.16 each.
  function automatic logic [53:0] stable_coefs();
    int a2, a1, b0, lim;
    a2  = $urandom_range(16384, 64880);
    lim = 65536 + a2 - 1024;
    a1  = int'($urandom_range(0, 2 * lim)) - lim;
    b0  = int'($urandom_range(0, 16000)) - 8000;
    return {18'(a2), 18'(a1), 18'(b0)};
  endfunction

  // One config write per clock; caller lowers cfg_write after the last one.
  task automatic write_reg(cfg_idx_t idx, logic [53:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Offer one input request after an optional gap; returns at the edge it is taken.
  // With no gap valid simply stays high into the next request.
  task automatic offer_sample(logic signed [15:0] s, logic be, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    block_end <= be;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every predicted output has come back, plus a little slack so the
  // sequencer is back in idle before any register changes.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, ready throughout
  // the steady phases.
  initial begin : receiver
    int hold;
    int hold_seen;
    int len;
    hold      = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (hold_seen != hold_ticket) begin
        // block fills: one result parked in the output register, next sample
        // taken and finished, then in_ready must drop while the sender keeps offering
        hold_seen = hold_ticket;
        hold      = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        len = idle_len();
        if (len > 0) begin
          hold      = len - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners first, then random phases each with a fresh setting.
  initial begin : stimulus
    logic signed [15:0] extreme_run [8];
    logic [53:0]        coef;
    int unsigned        pick;
    int unsigned        count;
    int unsigned        scale;
    logic signed [15:0] s;

    extreme_run = '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                    16'sd0, -16'sd1, 16'sd1, 16'sd32767};

    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_COEF_A;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    block_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset setting: all coefficients zero, so full-scale input gives silence
    offer_sample(16'sd32767, 1'b1, idle_len());
    offer_sample(-16'sd32768, 1'b0, idle_len());
    drain();

    // stable filters on all five formants at unity scale, field extremes
    for (int k = 0; k < NUM_COEF_REGS; k++)
      write_reg(cfg_idx_t'(REG_COEF_A + k), stable_coefs());
    write_reg(REG_FORMANTS, 54'(5));
    write_reg(REG_SCALE, 54'(32768));
    cfg_write <= 1'b0;
    for (int i = 0; i < 8; i++)
      offer_sample(extreme_run[i], (i == 7), idle_len());
    drain();

    // formant one set up to saturate; no formants in use gives zero output
    write_reg(REG_COEF_A, {18'd0, 18'h20000, 18'h1FFFF});
    write_reg(REG_FORMANTS, 54'(0));
    cfg_write <= 1'b0;
    offer_sample(16'sd32767, 1'b0, idle_len());
    offer_sample(-16'sd32768, 1'b1, idle_len());
    drain();

    // count above the bank size is clipped to five
    write_reg(REG_FORMANTS, 54'(7));
    cfg_write <= 1'b0;
    offer_sample(16'sd32767, 1'b0, idle_len());
    offer_sample(-16'sd32768, 1'b0, idle_len());
    offer_sample(16'sd32767, 1'b1, idle_len());
    drain();

    // scale near two: output saturates
    write_reg(REG_SCALE, 54'(65535));
    cfg_write <= 1'b0;
    offer_sample(-16'sd32768, 1'b0, idle_len());
    offer_sample(16'sd32767, 1'b0, idle_len());
    offer_sample(16'sd12345, 1'b1, idle_len());
    drain();

    // zero scale
    write_reg(REG_SCALE, 54'(0));
    cfg_write <= 1'b0;
    offer_sample(16'sd32767, 1'b0, idle_len());
    drain();

    // write to a missing register must change nothing
    write_reg(REG_SCALE, 54'(32768));
    write_reg(REG_UNUSED, '1);
    cfg_write <= 1'b0;
    offer_sample(-16'sd1, 1'b0, idle_len());
    offer_sample(16'sd1, 1'b1, idle_len());
    drain();

    for (int p = 0; p < PHASES; p++) begin
      steady = (p % 4 == 3);
      for (int k = 0; k < NUM_COEF_REGS; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 12)
          coef = stable_coefs();
        else if (pick < 17)
          coef = 54'({$urandom, $urandom});
        else if (pick == 17)
          coef = '1;
        else if (pick == 18)
          coef = '0;
        else
          coef = {18'd0, 18'h20000, 18'h1FFFF};
        write_reg(cfg_idx_t'(REG_COEF_A + k), coef);
      end
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
      write_reg(REG_FORMANTS, 54'(count));
      case ($urandom_range(0, 9))
        0:       scale = 0;
        1:       scale = 65535;
        2:       scale = 32768;
        3:       scale = $urandom_range(0, 65535);
        default: scale = (count >= 1 && count <= 5) ? norm_gain[count] : SCALE_RESET;
      endcase
      write_reg(REG_SCALE, 54'(scale));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, 54'({$urandom, $urandom}));
      cfg_write <= 1'b0;

      // one phase runs against a long output stall
      if (p == 1)
        hold_ticket++;

      for (int i = 0; i < PER_PHASE; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          s = $signed(16'($urandom));
        else if (pick < 8)
          s = 16'(int'($urandom_range(0, 4000)) - 2000);
        else
          case ($urandom_range(0, 3))
            0:       s = 16'sd32767;
            1:       s = -16'sd32768;
            2:       s = -16'sd1;
            default: s = 16'sd0;
          endcase
        offer_sample(s, ($urandom_range(0, 15) == 0), steady ? 0 : idle_len());
      end
      drain();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
